### hdl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// shared widths, codes, register map and beat types for the lift supervisor
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int POS_W  = 14;
	localparam int DUTY_W = 16;
	localparam int TIME_W = 16;
	localparam int CFG_W  = 16;
	localparam int COMP_W = 3;
	localparam int SEL_W  = 2;

	// idle ticks between potentiometer samples
	localparam int SAMPLE_INTERVAL = 50;
	localparam int IDLE_W = (SAMPLE_INTERVAL > 2) ? $clog2(SAMPLE_INTERVAL) : 1;

	// -0.1 in q1.15, rounded to nearest
	localparam logic signed [DUTY_W-1:0] PULSE_DUTY = -16'sd3277;

	localparam int NUM_PEGS = 6;
	localparam int PEG_IDX_W = $clog2(NUM_PEGS);

	// register map
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_TIMEOUT      = 3'd0,
		REG_DEADBAND     = 3'd1,
		REG_LOW_COL_LOW  = 3'd2,
		REG_LOW_COL_MED  = 3'd3,
		REG_LOW_COL_HIGH = 3'd4,
		REG_HIGH_COL_LOW = 3'd5,
		REG_HIGH_COL_MED = 3'd6,
		REG_HIGH_COL_HIGH = 3'd7
	} reg_idx_t;

	localparam logic [TIME_W-1:0] TIMEOUT_RST  = 16'd75;
	localparam logic [POS_W-1:0]  DEADBAND_RST = 14'd410;
	localparam logic [POS_W-1:0]  PEG_RST [NUM_PEGS] = '{
		14'd1761, 14'd2048, 14'd2048, 14'd2048, 14'd2048, 14'd8847
	};
	// peg slots that double as soft limits
	localparam int PEG_LOWER_LIMIT = 0;
	localparam int PEG_UPPER_LIMIT = NUM_PEGS - 1;

	// preset selection codes
	localparam logic [SEL_W-1:0] SEL_STOWED = 2'd0;
	localparam logic [SEL_W-1:0] SEL_LOW    = 2'd1;

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_ABORT   = 5'b00010,
		MODE_MANUAL  = 5'b00100,
		MODE_PRESET  = 5'b01000,
		MODE_PULSING = 5'b10000
	} mode_t;

	typedef enum logic [COMP_W-1:0] {
		COMP_NONE     = 3'd0,
		COMP_PROGRESS = 3'd1,
		COMP_SUCCESS  = 3'd2,
		COMP_FAILURE  = 3'd3,
		COMP_ABORTED  = 3'd4
	} comp_t;

	typedef struct packed {
		logic                     new_command;
		logic                     manual_request;
		logic                     high_column;
		logic [SEL_W-1:0]         preset_select;
		logic signed [DUTY_W-1:0] manual_power;
		logic                     abort_request;
		logic [POS_W-1:0]         pot_position;
	} cmd_t;

	typedef struct packed {
		logic                     drive_enabled;
		logic                     duty_mode;
		logic signed [DUTY_W-1:0] duty_out;
		logic [POS_W-1:0]         setpoint_out;
		logic [COMP_W-1:0]        completion;
		logic                     arm_top_request;
		logic                     sample_pot;
	} rsp_t;

endpackage

### hdl/lps_cmd_if.sv
// ----------------------------------------------------------------------------
// lps_cmd_if
// command channel: one control tick of inputs per beat
// ----------------------------------------------------------------------------
interface lps_cmd_if;
	logic                             valid;
	logic                             ready;
	logic                             new_command;
	logic                             manual_request;
	logic                             high_column;
	logic [lps_pkg::SEL_W-1:0]        preset_select;
	logic signed [lps_pkg::DUTY_W-1:0] manual_power;
	logic                             abort_request;
	logic [lps_pkg::POS_W-1:0]        pot_position;

	modport source (
		output valid, new_command, manual_request, high_column, preset_select,
		output manual_power, abort_request, pot_position,
		input  ready
	);
	modport sink (
		input  valid, new_command, manual_request, high_column, preset_select,
		input  manual_power, abort_request, pot_position,
		output ready
	);
endinterface

### hdl/lps_rsp_if.sv
// ----------------------------------------------------------------------------
// lps_rsp_if
// result channel: one motor command and status per beat
// ----------------------------------------------------------------------------
interface lps_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             drive_enabled;
	logic                             duty_mode;
	logic signed [lps_pkg::DUTY_W-1:0] duty_out;
	logic [lps_pkg::POS_W-1:0]        setpoint_out;
	logic [lps_pkg::COMP_W-1:0]       completion;
	logic                             arm_top_request;
	logic                             sample_pot;

	modport source (
		output valid, drive_enabled, duty_mode, duty_out, setpoint_out,
		output completion, arm_top_request, sample_pot,
		input  ready
	);
	modport sink (
		input  valid, drive_enabled, duty_mode, duty_out, setpoint_out,
		input  completion, arm_top_request, sample_pot,
		output ready
	);
endinterface

### hdl/lps_cfg_if.sv
// ----------------------------------------------------------------------------
// lps_cfg_if
// register write channel: index and data per beat
// ----------------------------------------------------------------------------
interface lps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [lps_pkg::REG_IDX_W-1:0]   index;
	logic [lps_pkg::CFG_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### hdl/lift_preset_supervisor.sv
// ----------------------------------------------------------------------------
// lift_preset_supervisor
// per-tick lift motor supervisor: abort, manual, preset, pulse-down and idle modes
// ----------------------------------------------------------------------------
//
//  port   dir    beat carries
//  -----  -----  ------------------------------------------------------------
//  cmd    sink   command flags, preset choice, manual power, abort, pot
//  rsp    source drive enable, duty mode, duty, setpoint, completion, flags
//  cfg    sink   register index and write data (always ready)
//
//  one beat in, one beat out; a beat may enter every cycle while rsp does not stall
//  a beat passes through the input register, then the result register
//  the supervisor state advances when a beat moves into the result register
//  a stalled rsp holds the result register, and cmd keeps taking one more beat
//  arst_n clears valids, countdown, status and idle counter, sets mode to idle and reloads registers
//
module lift_preset_supervisor (
	input  logic         clk,
	input  logic         arst_n,
	lps_cmd_if.sink      cmd,
	lps_rsp_if.source    rsp,
	lps_cfg_if.sink      cfg
);

	// configuration registers
	logic [lps_pkg::TIME_W-1:0] timeout_q;
	logic [lps_pkg::POS_W-1:0]  deadband_q;
	logic [lps_pkg::POS_W-1:0]  peg_q [lps_pkg::NUM_PEGS];

	// supervisor state
	lps_pkg::mode_t             mode_q;
	logic [lps_pkg::TIME_W-1:0] countdown_q;
	logic                       pos_mode_q;
	lps_pkg::comp_t             comp_q;
	logic [lps_pkg::IDLE_W-1:0] idle_cnt_q;

	// pipeline
	logic          valid_s1;
	lps_pkg::cmd_t item_s1;
	logic          valid_s2;
	lps_pkg::rsp_t result_s2;
	logic          advance;

	// next-state and result logic
	lps_pkg::mode_t             mode_v;
	lps_pkg::mode_t             mode_nx;
	logic [lps_pkg::TIME_W-1:0] countdown_v;
	logic [lps_pkg::TIME_W-1:0] countdown_nx;
	logic                       pos_mode_nx;
	lps_pkg::comp_t             comp_nx;
	logic [lps_pkg::IDLE_W-1:0] idle_cnt_nx;
	lps_pkg::rsp_t              result_nx;
	logic [lps_pkg::PEG_IDX_W-1:0] peg_idx;
	logic [lps_pkg::POS_W-1:0]  setpoint;
	logic [lps_pkg::POS_W-1:0]  pos_err;
	logic                       in_band;
	logic                       power_pos;
	logic                       power_neg;

	// ---------------------------------------------------------------- handshake
	// s1 moves on when the result register is empty or being drained
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// input register, payload only
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.new_command    <= cmd.new_command;
			item_s1.manual_request <= cmd.manual_request;
			item_s1.high_column    <= cmd.high_column;
			item_s1.preset_select  <= cmd.preset_select;
			item_s1.manual_power   <= cmd.manual_power;
			item_s1.abort_request  <= cmd.abort_request;
			item_s1.pot_position   <= cmd.pot_position;
		end
	end

	// ---------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= lps_pkg::TIMEOUT_RST;
			deadband_q <= lps_pkg::DEADBAND_RST;
			for (int i = 0; i < lps_pkg::NUM_PEGS; i++) begin
				peg_q[i] <= lps_pkg::PEG_RST[i];
			end
		end else if (cfg.valid) begin
			unique case (lps_pkg::reg_idx_t'(cfg.index))
				lps_pkg::REG_TIMEOUT:       timeout_q  <= cfg.data;
				lps_pkg::REG_DEADBAND:      deadband_q <= cfg.data[lps_pkg::POS_W-1:0];
				lps_pkg::REG_LOW_COL_LOW:   peg_q[0]   <= cfg.data[lps_pkg::POS_W-1:0];
				lps_pkg::REG_LOW_COL_MED:   peg_q[1]   <= cfg.data[lps_pkg::POS_W-1:0];
				lps_pkg::REG_LOW_COL_HIGH:  peg_q[2]   <= cfg.data[lps_pkg::POS_W-1:0];
				lps_pkg::REG_HIGH_COL_LOW:  peg_q[3]   <= cfg.data[lps_pkg::POS_W-1:0];
				lps_pkg::REG_HIGH_COL_MED:  peg_q[4]   <= cfg.data[lps_pkg::POS_W-1:0];
				lps_pkg::REG_HIGH_COL_HIGH: peg_q[5]   <= cfg.data[lps_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- preset geometry
	// high column pegs sit three slots above the low column ones
	assign peg_idx = lps_pkg::PEG_IDX_W'({1'b0, item_s1.preset_select} - 3'd1)
		+ (item_s1.high_column ? lps_pkg::PEG_IDX_W'(3) : lps_pkg::PEG_IDX_W'(0));
	assign setpoint = (item_s1.preset_select == lps_pkg::SEL_STOWED) ? '0 : peg_q[peg_idx];
	assign pos_err  = (item_s1.pot_position >= setpoint) ? item_s1.pot_position - setpoint
		: setpoint - item_s1.pot_position;
	assign in_band  = pos_err < deadband_q;

	assign power_pos = !item_s1.manual_power[lps_pkg::DUTY_W-1] && (item_s1.manual_power != '0);
	assign power_neg = item_s1.manual_power[lps_pkg::DUTY_W-1];

	// ---------------------------------------------------------------- tick logic
	always_comb begin
		mode_v       = mode_q;
		countdown_v  = countdown_q;
		pos_mode_nx  = pos_mode_q;
		comp_nx      = comp_q;
		idle_cnt_nx  = idle_cnt_q;
		countdown_nx = countdown_q;
		result_nx    = '0;

		// a new command picks the mode, abort then overrides it
		if (item_s1.new_command) begin
			if (item_s1.manual_request) begin
				pos_mode_nx = 1'b0;
				mode_v      = lps_pkg::MODE_MANUAL;
			end else begin
				pos_mode_nx = 1'b1;
				countdown_v = timeout_q;
				mode_v      = lps_pkg::MODE_PRESET;
			end
		end
		if (item_s1.abort_request) begin
			mode_v = lps_pkg::MODE_ABORT;
		end
		mode_nx      = mode_v;
		countdown_nx = countdown_v;

		unique case (mode_v)
			lps_pkg::MODE_ABORT: begin
				comp_nx = lps_pkg::COMP_ABORTED;
			end
			lps_pkg::MODE_PULSING: begin
				result_nx.drive_enabled = 1'b1;
				result_nx.sample_pot    = 1'b1;
				pos_mode_nx             = 1'b0;
				if (item_s1.pot_position >= peg_q[lps_pkg::PEG_LOWER_LIMIT]) begin
					result_nx.duty_out = lps_pkg::PULSE_DUTY;
				end
			end
			lps_pkg::MODE_MANUAL: begin
				result_nx.drive_enabled = 1'b1;
				result_nx.sample_pot    = 1'b1;
				comp_nx                 = lps_pkg::COMP_PROGRESS;
				// soft limits
				if ((power_pos && item_s1.pot_position < peg_q[lps_pkg::PEG_UPPER_LIMIT]) ||
					(power_neg && item_s1.pot_position > peg_q[lps_pkg::PEG_LOWER_LIMIT])) begin
					result_nx.duty_out = item_s1.manual_power;
				end
				mode_nx = lps_pkg::MODE_IDLE;
			end
			lps_pkg::MODE_PRESET: begin
				result_nx.drive_enabled = 1'b1;
				result_nx.sample_pot    = 1'b1;
				result_nx.setpoint_out  = setpoint;
				result_nx.arm_top_request = !in_band;
				comp_nx = in_band ? lps_pkg::COMP_SUCCESS : lps_pkg::COMP_PROGRESS;
				if (countdown_v != '0) begin
					countdown_nx = countdown_v - 1'b1;
				end
				// failure and the next mode are judged only when the countdown runs out
				if (countdown_nx == '0) begin
					if (!in_band) begin
						comp_nx = lps_pkg::COMP_FAILURE;
					end
					if (in_band && item_s1.preset_select == lps_pkg::SEL_LOW) begin
						mode_nx = lps_pkg::MODE_PULSING;
					end else begin
						mode_nx = lps_pkg::MODE_IDLE;
					end
				end
			end
			default: begin
				mode_nx = lps_pkg::MODE_IDLE;
				if (idle_cnt_q == lps_pkg::IDLE_W'(lps_pkg::SAMPLE_INTERVAL - 1)) begin
					idle_cnt_nx          = '0;
					result_nx.sample_pot = 1'b1;
				end else begin
					idle_cnt_nx = idle_cnt_q + 1'b1;
				end
				// controller left in voltage mode after a manual beat
				if (!pos_mode_nx) begin
					comp_nx = lps_pkg::COMP_SUCCESS;
				end
			end
		endcase

		if (pos_mode_nx) begin
			result_nx.duty_out = '0;
		end
		result_nx.duty_mode  = !pos_mode_nx;
		result_nx.completion = comp_nx;
	end

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= lps_pkg::MODE_IDLE;
			countdown_q <= '0;
			pos_mode_q  <= 1'b1;
			comp_q      <= lps_pkg::COMP_NONE;
			idle_cnt_q  <= '0;
		end else if (advance) begin
			mode_q      <= mode_nx;
			countdown_q <= countdown_nx;
			pos_mode_q  <= pos_mode_nx;
			comp_q      <= comp_nx;
			idle_cnt_q  <= idle_cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nx;
		end
	end

	// ---------------------------------------------------------------- result port
	assign rsp.valid           = valid_s2;
	assign rsp.drive_enabled   = result_s2.drive_enabled;
	assign rsp.duty_mode       = result_s2.duty_mode;
	assign rsp.duty_out        = result_s2.duty_out;
	assign rsp.setpoint_out    = result_s2.setpoint_out;
	assign rsp.completion      = result_s2.completion;
	assign rsp.arm_top_request = result_s2.arm_top_request;
	assign rsp.sample_pot      = result_s2.sample_pot;

endmodule
